/* rtl/mvps_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables of the metaball Voronoi pixel shader core.
package mvps_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_SHADE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_COLOUR_ZERO = 3'd0,
    REG_COLOUR_ONE  = 3'd1,
    REG_COLOUR_TWO  = 3'd2,
    REG_BACKGROUND  = 3'd3,
    REG_SEAM        = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgCount = 5;
  localparam int unsigned ColourW  = 5;
  localparam logic [ColourW-1:0] CfgReset [CfgCount] = '{5'd9, 5'd12, 5'd8, 5'd0, 5'd15};

  localparam int unsigned FieldW   = 30;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned LaneDenW = 34;
  localparam int unsigned RatDenW  = 31;

  localparam logic [FieldW-1:0]  BgLimit   = 30'd22938;
  localparam logic [RatDenW-1:0] Eps       = 31'd66;
  localparam logic [RatioW-1:0]  RatioBase = 16'd52429;
  localparam int EdgeMargin = 5;

  localparam logic [3:0] Bayer [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  function automatic cfg_reg_e colour_slot(logic [2:0] blob);
    cfg_reg_e slot;
    case (blob)
      3'd0, 3'd3, 3'd6: slot = REG_COLOUR_ZERO;
      3'd1, 3'd4, 3'd7: slot = REG_COLOUR_ONE;
      default:          slot = REG_COLOUR_TWO;
    endcase
    return slot;
  endfunction

endpackage

/* rtl/metaball_voronoi_pixel_shader_core.sv */
`timescale 1ns / 1ps
// Top level of the metaball Voronoi pixel shader core.
// The input channel takes one command item per cycle: load a blob, move all
// blobs by one frame tick, or shade a pixel. Load and tick items take effect
// in the cycle they are accepted and give no result. Each shade item gives one
// result item on the output channel: palette colour, owning blob and seam flag.
// A shade item sees the blob table as it stands when it is accepted.
// Throughput is one item per cycle while the receiver does not stall. A shade
// result passes the lane registers, the 30 quotient bits of the per-blob field
// dividers, the top-two tree, the ratio operand registers and the 16 quotient
// bits of the ratio divider, then the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and the
// input stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears the blob table to zero, loads the palette registers with their
// defaults and empties the pipeline. Palette registers must be written through the
// configuration port while the block is idle; the block does not enforce this.
module metaball_voronoi_pixel_shader_core #(
  parameter int BLOB_COUNT     = 12,
  parameter int COLOURED_BLOBS = 3,
  parameter int SCREEN_WIDTH   = 256,
  parameter int SCREEN_HEIGHT  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [3:0]        blob_index_i,
  input  logic [7:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  input  logic [15:0]       load_pos_x_i,
  input  logic [15:0]       load_pos_y_i,
  input  logic signed [8:0] load_vel_x_i,
  input  logic signed [8:0] load_vel_y_i,
  input  logic [13:0]       load_radius_sq_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        pixel_colour_o,
  output logic [3:0]        owner_blob_o,
  output logic              seam_hit_o
);

  localparam int IW  = $clog2(BLOB_COUNT);
  localparam int FW  = mvps_pkg::FieldW;
  localparam int RW  = mvps_pkg::RatioW;
  localparam int LDW = mvps_pkg::LaneDenW;
  localparam int RDW = mvps_pkg::RatDenW;
  localparam int D1  = 2 + FW + IW;

  logic advance;
  logic accept;
  logic out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign advance    = !(out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  logic [4:0] cfg_q [mvps_pkg::CfgCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mvps_pkg::CfgCount; i++) cfg_q[i] <= mvps_pkg::CfgReset[i];
    end else if (cfg_we_i && (32'(cfg_index_i) < 32'(mvps_pkg::CfgCount))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  logic [15:0] pos_x [BLOB_COUNT];
  logic [15:0] pos_y [BLOB_COUNT];
  logic [13:0] rad_sq [BLOB_COUNT];

  mvps_table #(
    .BLOB_COUNT   (BLOB_COUNT),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .command_i       (command_i),
    .blob_index_i    (blob_index_i),
    .load_pos_x_i    (load_pos_x_i),
    .load_pos_y_i    (load_pos_y_i),
    .load_vel_x_i    (load_vel_x_i),
    .load_vel_y_i    (load_vel_y_i),
    .load_radius_sq_i(load_radius_sq_i),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .radius_sq_o     (rad_sq)
  );

  logic       valid_a_q;
  logic [3:0] bayer_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      bayer_a_q <= '0;
    end else if (advance) begin
      valid_a_q <= accept && (mvps_pkg::cmd_e'(command_i) == mvps_pkg::CMD_SHADE);
      bayer_a_q <= mvps_pkg::Bayer[{pixel_y_i[1:0], pixel_x_i[1:0]}];
    end
  end

  logic [FW-1:0] field [BLOB_COUNT];

  for (genvar k = 0; k < BLOB_COUNT; k++) begin : g_lane
    logic signed [16:0] dx_q, dy_q;
    logic signed [33:0] sqx, sqy;
    logic [31:0]        sqx_q, sqy_q;
    logic [13:0]        r2_a_q, r2_b_q, r2_c_q;
    logic [LDW-1:0]     den_q;

    assign sqx = dx_q * dx_q;
    assign sqy = dy_q * dy_q;

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dx_q   <= $signed({1'b0, pixel_x_i, 8'd0}) - $signed({1'b0, pos_x[k]});
        dy_q   <= $signed({1'b0, pixel_y_i, 8'd0}) - $signed({1'b0, pos_y[k]});
        r2_a_q <= rad_sq[k];
        sqx_q  <= sqx[31:0];
        sqy_q  <= sqy[31:0];
        r2_b_q <= r2_a_q;
        den_q  <= {2'b00, sqx_q} + {2'b00, sqy_q} + LDW'(65536);
        r2_c_q <= r2_b_q;
      end
    end

    mvps_div #(
      .NW(14 + 32),
      .DW(LDW),
      .QW(FW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (advance),
      .num_i ({r2_c_q, 32'd0}),
      .den_i (den_q),
      .quot_o(field[k])
    );
  end

  logic [FW-1:0] c1, c2;
  logic [IW-1:0] best;

  mvps_top2 #(
    .N (BLOB_COUNT),
    .FW(FW),
    .IW(IW)
  ) u_top2 (
    .clk_i  (clk_i),
    .en_i   (advance),
    .field_i(field),
    .c1_o   (c1),
    .c2_o   (c2),
    .best_o (best)
  );

  logic       valid_t;
  logic [3:0] bayer_t;

  mvps_delay #(
    .W(5),
    .N(D1)
  ) u_delay_tree (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .d_i   ({valid_a_q, bayer_a_q}),
    .q_o   ({valid_t, bayer_t})
  );

  logic           valid_r_q;
  logic [3:0]     bayer_r_q;
  logic [IW-1:0]  best_r_q;
  logic           bg_r_q;
  logic [FW-1:0]  num_r_q;
  logic [RDW-1:0] den_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_r_q <= 1'b0;
    end else if (advance) begin
      valid_r_q <= valid_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bayer_r_q <= bayer_t;
      best_r_q  <= best;
      bg_r_q    <= (c1 < mvps_pkg::BgLimit);
      num_r_q   <= c2;
      den_r_q   <= {1'b0, c1} + mvps_pkg::Eps;
    end
  end

  logic [RW-1:0] ratio;

  mvps_div #(
    .NW(FW + RW),
    .DW(RDW),
    .QW(RW)
  ) u_div_ratio (
    .clk_i (clk_i),
    .en_i  (advance),
    .num_i ({num_r_q, 16'd0}),
    .den_i (den_r_q),
    .quot_o(ratio)
  );

  logic          valid_s;
  logic [3:0]    bayer_s;
  logic [IW-1:0] best_s;
  logic          bg_s;

  mvps_delay #(
    .W(6 + IW),
    .N(RW)
  ) u_delay_ratio (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .d_i   ({valid_r_q, bayer_r_q, best_r_q, bg_r_q}),
    .q_o   ({valid_s, bayer_s, best_s, bg_s})
  );

  logic [RW-1:0] diff;
  logic [17:0]   sf;
  logic [15:0]   thr;
  logic          seam_d;
  logic [4:0]    owner_colour;
  logic [4:0]    colour_d;

  assign diff   = ratio - mvps_pkg::RatioBase;
  assign sf     = {diff, 2'b00} + {2'b00, diff};
  assign thr    = {bayer_s, 1'b1, 11'd0};
  assign seam_d = !bg_s && (ratio > mvps_pkg::RatioBase) && (sf > {2'b00, thr});

  assign owner_colour = (32'(best_s) < 32'(COLOURED_BLOBS)) ?
                        cfg_q[mvps_pkg::colour_slot(3'(best_s))] :
                        cfg_q[mvps_pkg::REG_BACKGROUND];

  always_comb begin
    if (bg_s) begin
      colour_d = cfg_q[mvps_pkg::REG_BACKGROUND];
    end else if (seam_d) begin
      colour_d = cfg_q[mvps_pkg::REG_SEAM];
    end else begin
      colour_d = owner_colour;
    end
  end

  logic [4:0] colour_q;
  logic [3:0] owner_q;
  logic       seam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      colour_q <= colour_d;
      owner_q  <= 4'(best_s);
      seam_q   <= seam_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_colour_o = colour_q;
  assign owner_blob_o   = owner_q;
  assign seam_hit_o     = seam_q;

endmodule

/* rtl/mvps_delay.sv */
`timescale 1ns / 1ps
// Enabled shift line that carries side information along the pipeline.
module mvps_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < N; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[N-1];

endmodule

/* rtl/mvps_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
module mvps_div #(
  parameter int NW = 46,
  parameter int DW = 34,
  parameter int QW = 30
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quot_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] lq_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lq_in;
    logic [DW:0]   t;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i >> QW);
      assign den_in = den_i;
      assign lq_in  = num_i[QW-1:0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lq_in  = lq_q[k-1];
    end
    assign t  = {rem_in, lq_in[QW-1]};
    assign ge = (t >= {1'b0, den_in});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(t - {1'b0, den_in}) : DW'(t);
        den_q[k] <= den_in;
        lq_q[k]  <= {lq_in[QW-2:0], ge};
      end
    end
  end

  assign quot_o = lq_q[QW-1];

endmodule

/* rtl/mvps_top2.sv */
`timescale 1ns / 1ps
// Registered tree that finds the strongest and second strongest field.
module mvps_top2 #(
  parameter int N  = 12,
  parameter int FW = 30,
  parameter int IW = 4
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [FW-1:0] field_i [N],
  output logic [FW-1:0] c1_o,
  output logic [FW-1:0] c2_o,
  output logic [IW-1:0] best_o
);

  localparam int Leaves = 2 ** $clog2(N);
  localparam int Inner  = Leaves - 1;
  localparam int Nodes  = 2 * Leaves - 1;

  logic [FW-1:0] n1 [Nodes];
  logic [FW-1:0] n2 [Nodes];
  logic [IW-1:0] ni [Nodes];
  logic [FW-1:0] c1_q [Inner];
  logic [FW-1:0] c2_q [Inner];
  logic [IW-1:0] bi_q [Inner];

  for (genvar n = 0; n < Inner; n++) begin : g_inner
    assign n1[n] = c1_q[n];
    assign n2[n] = c2_q[n];
    assign ni[n] = bi_q[n];
  end

  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign n1[Inner+j] = field_i[j];
    end else begin : g_pad
      assign n1[Inner+j] = '0;
    end
    assign n2[Inner+j] = '0;
    assign ni[Inner+j] = IW'(j);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < Inner; n++) begin
        if (n1[2*n+2] > n1[2*n+1]) begin
          c1_q[n] <= n1[2*n+2];
          bi_q[n] <= ni[2*n+2];
          c2_q[n] <= (n1[2*n+1] > n2[2*n+2]) ? n1[2*n+1] : n2[2*n+2];
        end else begin
          c1_q[n] <= n1[2*n+1];
          bi_q[n] <= ni[2*n+1];
          c2_q[n] <= (n2[2*n+1] > n1[2*n+2]) ? n2[2*n+1] : n1[2*n+2];
        end
      end
    end
  end

  assign c1_o   = c1_q[0];
  assign c2_o   = c2_q[0];
  assign best_o = bi_q[0];

endmodule

/* rtl/mvps_table.sv */
`timescale 1ns / 1ps
// Blob table with load and per-frame motion with edge bounce.
module mvps_table #(
  parameter int BLOB_COUNT    = 12,
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         command_i,
  input  logic [3:0]         blob_index_i,
  input  logic [15:0]        load_pos_x_i,
  input  logic [15:0]        load_pos_y_i,
  input  logic signed [8:0]  load_vel_x_i,
  input  logic signed [8:0]  load_vel_y_i,
  input  logic [13:0]        load_radius_sq_i,
  output logic [15:0]        pos_x_o [BLOB_COUNT],
  output logic [15:0]        pos_y_o [BLOB_COUNT],
  output logic [13:0]        radius_sq_o [BLOB_COUNT]
);

  localparam int IW = $clog2(BLOB_COUNT);
  localparam logic signed [17:0] Lo  = 18'(mvps_pkg::EdgeMargin * 256);
  localparam logic signed [17:0] HiX = 18'((SCREEN_WIDTH - mvps_pkg::EdgeMargin) * 256);
  localparam logic signed [17:0] HiY = 18'((SCREEN_HEIGHT - mvps_pkg::EdgeMargin) * 256);

  logic [15:0]       px_q [BLOB_COUNT];
  logic [15:0]       py_q [BLOB_COUNT];
  logic signed [8:0] vx_q [BLOB_COUNT];
  logic signed [8:0] vy_q [BLOB_COUNT];
  logic [13:0]       r2_q [BLOB_COUNT];
  logic [15:0]       px_d [BLOB_COUNT];
  logic [15:0]       py_d [BLOB_COUNT];
  logic signed [8:0] vx_d [BLOB_COUNT];
  logic signed [8:0] vy_d [BLOB_COUNT];

  mvps_pkg::cmd_e cmd;
  logic           load_ok;

  assign cmd     = mvps_pkg::cmd_e'(command_i);
  assign load_ok = (32'(blob_index_i) < 32'(BLOB_COUNT));

  function automatic logic signed [8:0] flip(logic signed [8:0] v);
    logic signed [9:0] n;
    n = -{v[8], v};
    return (v == -9'sd256) ? 9'sd255 : n[8:0];
  endfunction

  function automatic logic [24:0] move(logic [15:0] pos, logic signed [8:0] vel,
                                       logic signed [17:0] hi);
    logic signed [17:0] p;
    logic signed [8:0]  v;
    p = $signed({2'b00, pos}) + {{9{vel[8]}}, vel};
    v = (p < Lo || p > hi) ? flip(vel) : vel;
    if (p < Lo) p = Lo;
    if (p > hi) p = hi;
    return {p[15:0], v};
  endfunction

  always_comb begin
    for (int i = 0; i < BLOB_COUNT; i++) begin
      {px_d[i], vx_d[i]} = move(px_q[i], vx_q[i], HiX);
      {py_d[i], vy_d[i]} = move(py_q[i], vy_q[i], HiY);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOB_COUNT; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        r2_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (cmd == mvps_pkg::CMD_LOAD && load_ok) begin
        px_q[IW'(blob_index_i)] <= load_pos_x_i;
        py_q[IW'(blob_index_i)] <= load_pos_y_i;
        vx_q[IW'(blob_index_i)] <= load_vel_x_i;
        vy_q[IW'(blob_index_i)] <= load_vel_y_i;
        r2_q[IW'(blob_index_i)] <= load_radius_sq_i;
      end else if (cmd == mvps_pkg::CMD_TICK) begin
        for (int i = 0; i < BLOB_COUNT; i++) begin
          px_q[i] <= px_d[i];
          py_q[i] <= py_d[i];
          vx_q[i] <= vx_d[i];
          vy_q[i] <= vy_d[i];
        end
      end
    end
  end

  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign radius_sq_o = r2_q;

endmodule
